// ===== rtl/shwa_pkg.sv =====
`timescale 1ns / 1ps

package shwa_pkg;

    localparam int HISTORY_DEPTH = 15;

    localparam int TIME_W    = 32;
    localparam int LEVEL_W   = 10;
    localparam int WIN_W     = 8;
    localparam int OUT_CNT_W = 4;
    localparam int MATCH_MAX = 15;

    // Index into the history, and a count that can also hold the depth itself.
    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    // Per-channel sum plus half the count still fits this width.
    localparam int SUM_W  = LEVEL_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    // Window length in seconds: at most 255 * 60.
    localparam int LIMIT_W = 14;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(15);

    localparam logic CMD_PUSH    = 1'b0;
    localparam logic CMD_AVERAGE = 1'b1;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } div_status_t;

endpackage

// ===== rtl/shwa_div.sv =====
`timescale 1ns / 1ps

module shwa_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [shwa_pkg::SUM_W-1:0] dividend,
    input  logic [shwa_pkg::CNT_W-1:0] divisor,
    output shwa_pkg::div_status_t      status
);
    import shwa_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  num_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W:0]    rem_reg;
    logic [LEVEL_W-1:0] quo_reg;

    logic [CNT_W:0] trial;
    logic [CNT_W:0] trial_sub;
    logic           fits;

    // Restoring division, one quotient bit per cycle. The mean never exceeds
    // the widest reading, so only the low quotient bits are kept.
    assign trial     = {rem_reg[CNT_W-1:0], num_reg[SUM_W-1]};
    assign fits      = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial_sub : trial;
            quo_reg <= {quo_reg[LEVEL_W-2:0], fits};
            num_reg <= {num_reg[SUM_W-2:0], 1'b0};
        end
    end

    assign status.busy     = busy_reg;
    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

// ===== rtl/sample_history_window_average.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// in        in_valid / in_stall      cmd, sample_time, current_time, fine_level, coarse_level
// out       out_valid / out_stall    newest_time, fine_mean, coarse_mean, match_count
// config    cfg_wr_en                cfg_wr_data (window_minutes)
//
// A push transaction does not stall, so it can be followed by a new input in the next cycle.
// An average request walks the history one entry per cycle, then, unless no entry matches,
// runs the shared bit-serial divider twice and loads the output register; in_stall stays
// high for all but the accepting cycle.
// A finished result moves to the output register, so inputs flow while out_stall holds it;
// the next average waits in its last state until that register is free.
// Reset empties the history and sets the window to 15 minutes; no clearing pass is needed.

module sample_history_window_average
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [shwa_pkg::TIME_W-1:0]    sample_time,
    input  logic [shwa_pkg::TIME_W-1:0]    current_time,
    input  logic [shwa_pkg::LEVEL_W-1:0]   fine_level,
    input  logic [shwa_pkg::LEVEL_W-1:0]   coarse_level,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [shwa_pkg::TIME_W-1:0]    newest_time,
    output logic [shwa_pkg::LEVEL_W-1:0]   fine_mean,
    output logic [shwa_pkg::LEVEL_W-1:0]   coarse_mean,
    output logic [shwa_pkg::OUT_CNT_W-1:0] match_count,

    input  logic                           cfg_wr_en,
    input  logic [shwa_pkg::WIN_W-1:0]     cfg_wr_data
);
    import shwa_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_WALK   = 3'd1;
    localparam logic [2:0] ST_DIV_F  = 3'd2;
    localparam logic [2:0] ST_DIV_C  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]         state_reg;
    logic [WIN_W-1:0]   window_reg;

    logic [TIME_W-1:0]  stamp_reg  [HISTORY_DEPTH];
    logic [LEVEL_W-1:0] fine_reg   [HISTORY_DEPTH];
    logic [LEVEL_W-1:0] coarse_reg [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] valid_reg;
    logic [CNT_W-1:0]   fill_count_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [SUM_W-1:0]   fine_sum_reg;
    logic [SUM_W-1:0]   coarse_sum_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TIME_W-1:0]  newest_reg;
    logic [LEVEL_W-1:0] fine_mean_reg;
    logic [LEVEL_W-1:0] coarse_mean_reg;

    logic               out_valid_reg;
    logic [TIME_W-1:0]  out_time_reg;
    logic [LEVEL_W-1:0] out_fine_reg;
    logic [LEVEL_W-1:0] out_coarse_reg;
    logic [OUT_CNT_W-1:0] out_count_reg;

    logic               in_take;
    logic               push_en;
    logic               avg_en;
    logic               full;
    logic [LIMIT_W-1:0] limit_now;

    logic [TIME_W-1:0]  sel_stamp;
    logic [TIME_W-1:0]  age_sec;
    logic               future;
    logic               hit;
    logic               walk_last;
    logic [SUM_W-1:0]   fine_sum_next;
    logic [SUM_W-1:0]   coarse_sum_next;
    logic [CNT_W-1:0]   cnt_next;

    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [CNT_W-1:0]   div_divisor;
    div_status_t        div_status;
    logic               load_out;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign push_en  = in_take && (cmd == CMD_PUSH);
    assign avg_en   = in_take && (cmd == CMD_AVERAGE);
    assign full     = (fill_count_reg == CNT_W'(HISTORY_DEPTH));

    // Whole minutes below the window is the same as seconds below window * 60.
    assign limit_now = {window_reg, 6'b0} - {{(LIMIT_W - WIN_W - 2){1'b0}}, window_reg, 2'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
        end
        else if (cfg_wr_en)
        begin
            window_reg <= cfg_wr_data;
        end
    end

    // History: fills slot by slot, then shifts toward slot 0 so entries run
    // from oldest to newest.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            fill_count_reg <= '0;
        end
        else if (push_en && !full)
        begin
            valid_reg[fill_count_reg[IDX_W-1:0]] <= 1'b1;
            fill_count_reg <= fill_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            if (full)
            begin
                for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                begin
                    stamp_reg[i]  <= stamp_reg[i + 1];
                    fine_reg[i]   <= fine_reg[i + 1];
                    coarse_reg[i] <= coarse_reg[i + 1];
                end
                stamp_reg[HISTORY_DEPTH - 1]  <= sample_time;
                fine_reg[HISTORY_DEPTH - 1]   <= fine_level;
                coarse_reg[HISTORY_DEPTH - 1] <= coarse_level;
            end
            else
            begin
                stamp_reg[fill_count_reg[IDX_W-1:0]]  <= sample_time;
                fine_reg[fill_count_reg[IDX_W-1:0]]   <= fine_level;
                coarse_reg[fill_count_reg[IDX_W-1:0]] <= coarse_level;
            end
        end
    end

    // One history entry is tested and accumulated per walk cycle.
    assign sel_stamp = stamp_reg[idx_reg];
    assign future    = now_reg < sel_stamp;
    assign age_sec   = now_reg - sel_stamp;
    assign hit       = valid_reg[idx_reg] &&
                       (future ? (window_reg != '0)
                               : (age_sec < {{(TIME_W - LIMIT_W){1'b0}}, limit_reg}));
    assign walk_last = (idx_reg == IDX_W'(HISTORY_DEPTH - 1));

    assign fine_sum_next   = fine_sum_reg +
                             (hit ? {{(SUM_W - LEVEL_W){1'b0}}, fine_reg[idx_reg]} : '0);
    assign coarse_sum_next = coarse_sum_reg +
                             (hit ? {{(SUM_W - LEVEL_W){1'b0}}, coarse_reg[idx_reg]} : '0);
    assign cnt_next        = cnt_reg + {{(CNT_W - 1){1'b0}}, hit};

    // If any entry matches, the fine mean starts straight off the last walk cycle, the
    // coarse mean when the fine one is done.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = coarse_sum_reg + SUM_W'({1'b0, cnt_reg[CNT_W-1:1]});
        div_divisor  = cnt_reg;
        case (state_reg)
            ST_WALK:
            begin
                div_start    = walk_last && (cnt_next != '0);
                div_dividend = fine_sum_next + SUM_W'({1'b0, cnt_next[CNT_W-1:1]});
                div_divisor  = cnt_next;
            end
            ST_DIV_F:
            begin
                div_start = div_status.done;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    shwa_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status)
    );

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (avg_en)
                    begin
                        state_reg <= ST_WALK;
                        idx_reg   <= '0;
                    end
                end
                ST_WALK:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (walk_last)
                    begin
                        state_reg <= (cnt_next != '0) ? ST_DIV_F : ST_DONE;
                    end
                end
                ST_DIV_F:
                begin
                    if (div_status.done)
                    begin
                        state_reg <= ST_DIV_C;
                    end
                end
                ST_DIV_C:
                begin
                    if (div_status.done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (avg_en)
        begin
            now_reg         <= current_time;
            limit_reg       <= limit_now;
            fine_sum_reg    <= '0;
            coarse_sum_reg  <= '0;
            cnt_reg         <= '0;
            newest_reg      <= '0;
            fine_mean_reg   <= '0;
            coarse_mean_reg <= '0;
        end
        else if (state_reg == ST_WALK)
        begin
            fine_sum_reg   <= fine_sum_next;
            coarse_sum_reg <= coarse_sum_next;
            cnt_reg        <= cnt_next;
            if (hit)
            begin
                newest_reg <= sel_stamp;
            end
        end
        else if (div_status.done && state_reg == ST_DIV_F)
        begin
            fine_mean_reg <= div_status.quotient;
        end
        else if (div_status.done && state_reg == ST_DIV_C)
        begin
            coarse_mean_reg <= div_status.quotient;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_time_reg   <= newest_reg;
            out_fine_reg   <= fine_mean_reg;
            out_coarse_reg <= coarse_mean_reg;
            out_count_reg  <= (32'(cnt_reg) > 32'(MATCH_MAX)) ? OUT_CNT_W'(MATCH_MAX)
                                                              : OUT_CNT_W'(cnt_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign newest_time = out_time_reg;
    assign fine_mean   = out_fine_reg;
    assign coarse_mean = out_coarse_reg;
    assign match_count = out_count_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("fill count beyond history depth");

    a_valid_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(fill_count_reg))
        else $error("valid marks disagree with fill count");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider restarted while busy");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_count_reg == '0) |->
            (out_time_reg == '0 && out_fine_reg == '0 && out_coarse_reg == '0))
        else $error("empty window gave a nonzero result");

    a_no_push_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(fill_count_reg))
        else $error("history changed during an average");

endmodule

// ===== dv/window_average_checker.sv =====
`timescale 1ns / 1ps

module window_average_checker
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           cmd,
    input  logic [shwa_pkg::TIME_W-1:0]    sample_time,
    input  logic [shwa_pkg::TIME_W-1:0]    current_time,
    input  logic [shwa_pkg::LEVEL_W-1:0]   fine_level,
    input  logic [shwa_pkg::LEVEL_W-1:0]   coarse_level,

    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [shwa_pkg::TIME_W-1:0]    newest_time,
    input  logic [shwa_pkg::LEVEL_W-1:0]   fine_mean,
    input  logic [shwa_pkg::LEVEL_W-1:0]   coarse_mean,
    input  logic [shwa_pkg::OUT_CNT_W-1:0] match_count,

    input  logic                           cfg_wr_en,
    input  logic [shwa_pkg::WIN_W-1:0]     cfg_wr_data,

    output int                             failures,
    output int                             outstanding
);

    import shwa_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [TIME_W-1:0]    newest;
        logic [LEVEL_W-1:0]   fine;
        logic [LEVEL_W-1:0]   coarse;
        logic [OUT_CNT_W-1:0] count;
    } window_result_t;

    logic [TIME_W-1:0]  stamp_hist  [HISTORY_DEPTH];
    logic [LEVEL_W-1:0] fine_hist   [HISTORY_DEPTH];
    logic [LEVEL_W-1:0] coarse_hist [HISTORY_DEPTH];
    logic               valid_hist  [HISTORY_DEPTH];
    int                 filled;
    logic [WIN_W-1:0]   window_min;
    window_result_t     expected_averages [$];
    int                 fail_total = 0;

    assign failures = fail_total;

    // Once the history is full, the oldest entry drops out and the new one goes last.
    function automatic void store_sample(input logic [TIME_W-1:0] stamp,
                                         input logic [LEVEL_W-1:0] fine,
                                         input logic [LEVEL_W-1:0] coarse);
        int slot;
        if (filled < HISTORY_DEPTH)
        begin
            slot = filled;
            filled++;
        end
        else
        begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++)
            begin
                stamp_hist[i]  = stamp_hist[i+1];
                fine_hist[i]   = fine_hist[i+1];
                coarse_hist[i] = coarse_hist[i+1];
                valid_hist[i]  = valid_hist[i+1];
            end
            slot = HISTORY_DEPTH - 1;
        end
        stamp_hist[slot]  = stamp;
        fine_hist[slot]   = fine;
        coarse_hist[slot] = coarse;
        valid_hist[slot]  = 1'b1;
    endfunction

    function automatic window_result_t predict_window_average(input logic [TIME_W-1:0] now);
        window_result_t    res;
        logic [63:0]       fine_sum;
        logic [63:0]       coarse_sum;
        logic [TIME_W-1:0] age;
        int                hits;
        res        = '0;
        fine_sum   = '0;
        coarse_sum = '0;
        hits       = 0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
        begin
            if (valid_hist[i])
            begin
                // A stamp later than the present time counts as zero minutes old.
                age = (now >= stamp_hist[i]) ? (now - stamp_hist[i]) / 32'd60 : '0;
                if (age < window_min)
                begin
                    fine_sum   += fine_hist[i];
                    coarse_sum += coarse_hist[i];
                    res.newest  = stamp_hist[i];
                    hits++;
                end
            end
        end
        if (hits != 0)
        begin
            res.fine   = LEVEL_W'((fine_sum + 64'(hits / 2)) / 64'(hits));
            res.coarse = LEVEL_W'((coarse_sum + 64'(hits / 2)) / 64'(hits));
            res.count  = OUT_CNT_W'((hits > MATCH_MAX) ? MATCH_MAX : hits);
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_result_t got;
        window_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < HISTORY_DEPTH; i++)
                valid_hist[i] = 1'b0;
            filled     = 0;
            window_min = WINDOW_RESET;
            expected_averages.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                window_min = cfg_wr_data;

            if (in_valid && !in_stall)
            begin
                if (cmd == CMD_PUSH)
                    store_sample(sample_time, fine_level, coarse_level);
                else
                    expected_averages.push_back(predict_window_average(current_time));
            end

            if (out_valid && !out_stall)
            begin
                got = {newest_time, fine_mean, coarse_mean, match_count};
                if (expected_averages.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display({"%0t: result with no request pending: ",
                                  "newest %0d fine %0d coarse %0d count %0d"},
                                 $time, got.newest, got.fine, got.coarse, got.count);
                end
                else
                begin
                    want = expected_averages.pop_front();
                    if (got.newest !== want.newest || got.fine !== want.fine ||
                        got.coarse !== want.coarse || got.count !== want.count)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display({"%0t: average mismatch: expected newest %0d fine %0d ",
                                      "coarse %0d count %0d, got newest %0d fine %0d ",
                                      "coarse %0d count %0d"},
                                     $time, want.newest, want.fine, want.coarse, want.count,
                                     got.newest, got.fine, got.coarse, got.count);
                    end
                end
            end

            outstanding <= expected_averages.size();
        end
    end

endmodule

// ===== dv/sample_history_window_average_tb.sv =====
`timescale 1ns / 1ps

module sample_history_window_average_tb;

    import shwa_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 64;
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_ITEMS = 50;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic                 cmd          = CMD_PUSH;
    logic [TIME_W-1:0]    sample_time  = '0;
    logic [TIME_W-1:0]    current_time = '0;
    logic [LEVEL_W-1:0]   fine_level   = '0;
    logic [LEVEL_W-1:0]   coarse_level = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [TIME_W-1:0]    newest_time;
    logic [LEVEL_W-1:0]   fine_mean;
    logic [LEVEL_W-1:0]   coarse_mean;
    logic [OUT_CNT_W-1:0] match_count;
    logic                 cfg_wr_en    = 1'b0;
    logic [WIN_W-1:0]     cfg_wr_data  = '0;

    int                   failures;
    int                   outstanding;
    int                   cycles            = 0;
    int                   sender_idle_pct   = 0;
    int                   receiver_idle_pct = 0;
    logic [WIN_W-1:0]     window_now        = WINDOW_RESET;
    logic [TIME_W-1:0]    wall_clock        = '0;
    logic [WIN_W-1:0]     window_plan [SEGMENTS] =
        '{8'd1, 8'd255, 8'd0, 8'd15, 8'd100, 8'd3, 8'd254, 8'd60, 8'd7, 8'd200, 8'd1, 8'd30};

    sample_history_window_average i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .sample_time  (sample_time),
        .current_time (current_time),
        .fine_level   (fine_level),
        .coarse_level (coarse_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .newest_time  (newest_time),
        .fine_mean    (fine_mean),
        .coarse_mean  (coarse_mean),
        .match_count  (match_count),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    window_average_checker i_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .sample_time  (sample_time),
        .current_time (current_time),
        .fine_level   (fine_level),
        .coarse_level (coarse_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .newest_time  (newest_time),
        .fine_mean    (fine_mean),
        .coarse_mean  (coarse_mean),
        .match_count  (match_count),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_idle_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Returns at the edge where the transaction is taken, with in_valid still high.
    task automatic transfer(input logic op,
                            input logic [TIME_W-1:0] stamp,
                            input logic [TIME_W-1:0] now,
                            input logic [LEVEL_W-1:0] fine,
                            input logic [LEVEL_W-1:0] coarse);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        sample_time  <= stamp;
        current_time <= now;
        fine_level   <= fine;
        coarse_level <= coarse;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Holds off the sender until every requested average has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] minutes);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= minutes;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        window_now   = minutes;
    endtask

    task automatic directed_items();
        transfer(CMD_AVERAGE, '0, '0, '0, '0);
        transfer(CMD_PUSH, 32'd0, '1, 10'd0, 10'd1023);
        transfer(CMD_PUSH, 32'd60, '0, 10'd1023, 10'd0);
        // Present time zero puts the second stamp in the future.
        transfer(CMD_AVERAGE, '1, 32'd0, '1, '1);
        transfer(CMD_AVERAGE, '0, '1, '0, '0);
        transfer(CMD_PUSH, '1, '0, 10'd999, 10'd999);
        transfer(CMD_AVERAGE, '0, '1, '0, '0);
        // One second short of the window edge, then right on it.
        transfer(CMD_AVERAGE, '0, 32'd959, '0, '0);
        transfer(CMD_AVERAGE, '0, 32'd960, '0, '0);
        // Thirteen more pushes fill the history and push the oldest sample out.
        for (int k = 0; k < 13; k++)
            transfer(CMD_PUSH, TIME_W'(1000 + 60 * k), '0,
                     LEVEL_W'(k * 77), LEVEL_W'(1000 - k * 3));
        transfer(CMD_AVERAGE, '0, 32'd1750, '0, '0);
        transfer(CMD_AVERAGE, '0, 32'd959, '0, '0);
        wall_clock = 32'd1720;
    endtask

    task automatic random_item();
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] now;
        int                pick;
        span = (window_now == 0) ? 32'd60 : TIME_W'(window_now * 60);
        if ($urandom_range(99) < 65)
        begin
            if ($urandom_range(19) == 0)
                stamp = $urandom();
            else
            begin
                wall_clock += $urandom_range(span / 6 + 30);
                stamp = wall_clock;
            end
            transfer(CMD_PUSH, stamp, $urandom(), LEVEL_W'($urandom_range(1023)),
                     LEVEL_W'($urandom_range(1023)));
        end
        else
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                now = $urandom();
            else if (pick < 3)
                now = wall_clock + $urandom_range(3 * span + 60);
            else
                now = wall_clock - 120 + $urandom_range(span + 240);
            transfer(CMD_AVERAGE, $urandom(), now, LEVEL_W'($urandom_range(1023)),
                     LEVEL_W'($urandom_range(1023)));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct   = 31;
        receiver_idle_pct = 77;
        directed_items();

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 4)
                0:
                begin
                    sender_idle_pct   = 31;
                    receiver_idle_pct = 77;
                end
                1:
                begin
                    sender_idle_pct   = 77;
                    receiver_idle_pct = 31;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            set_window(window_plan[seg]);
            // One segment starts its timestamps just below the 32-bit wrap.
            if (seg == 5)
                wall_clock = 32'hFFFF_C000;
            repeat (SEGMENT_ITEMS) random_item();
        end

        drain();
        if (failures == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
